// ===== rtl/mer_pkg.sv =====
// Shared constants, controller states and datapath command/status types for the ellipse rasterizer.
package mer_pkg;

    localparam int MAX_RADIUS_DEF  = 31;
    localparam int COORD_WIDTH_DEF = 12;

    localparam int RAD_W       = 5;
    localparam int SQ_W        = 2 * RAD_W;
    localparam int MUL_A_W     = 14;
    localparam int MUL_B_W     = SQ_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int OFS_W       = 6;
    localparam int GRAD_W      = 20;
    localparam int DEC_W       = 28;
    localparam int CNT_W       = 6;
    localparam int MAX_RESULTS = 63;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_R1_MUL,
        ST_R1_INIT,
        ST_WALK,
        ST_R2_SQX,
        ST_R2_A,
        ST_R2_SQY,
        ST_R2_C,
        ST_R2_D,
        ST_R2_INIT,
        ST_R2_STEP
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SQ_RX,
        DP_SQ_RY,
        DP_R1_MUL,
        DP_R1_INIT,
        DP_EMIT,
        DP_R2_SQX,
        DP_R2_A,
        DP_R2_SQY,
        DP_R2_C,
        DP_R2_D,
        DP_R2_INIT,
        DP_R2_STEP
    } dp_op_t;

    typedef struct packed {
        logic emit_ok;
        logic last;
        logic need_r2;
    } dp_status_t;

endpackage

// ===== rtl/mer_ctrl.sv =====
// Sequencer for setup multiplies, the point walk and the region-two restart.
module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mer_pkg::dp_status_t status,
    output mer_pkg::dp_op_t     op
);

    mer_pkg::ctrl_state_t state_reg;
    mer_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mer_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = mer_pkg::DP_NOP;
        in_stall   = 1'b1;
        unique case (state_reg)
            mer_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    op         = mer_pkg::DP_LOAD;
                    state_next = mer_pkg::ST_SQ_RX;
                end
            end
            mer_pkg::ST_SQ_RX:
            begin
                op         = mer_pkg::DP_SQ_RX;
                state_next = mer_pkg::ST_SQ_RY;
            end
            mer_pkg::ST_SQ_RY:
            begin
                op         = mer_pkg::DP_SQ_RY;
                state_next = mer_pkg::ST_R1_MUL;
            end
            mer_pkg::ST_R1_MUL:
            begin
                op         = mer_pkg::DP_R1_MUL;
                state_next = mer_pkg::ST_R1_INIT;
            end
            mer_pkg::ST_R1_INIT:
            begin
                op         = mer_pkg::DP_R1_INIT;
                state_next = mer_pkg::ST_WALK;
            end
            mer_pkg::ST_WALK:
            begin
                op = mer_pkg::DP_EMIT;
                if (status.emit_ok)
                begin
                    if (status.last)
                    begin
                        state_next = mer_pkg::ST_IDLE;
                    end
                    else if (status.need_r2)
                    begin
                        state_next = mer_pkg::ST_R2_SQX;
                    end
                end
            end
            mer_pkg::ST_R2_SQX:
            begin
                op         = mer_pkg::DP_R2_SQX;
                state_next = mer_pkg::ST_R2_A;
            end
            mer_pkg::ST_R2_A:
            begin
                op         = mer_pkg::DP_R2_A;
                state_next = mer_pkg::ST_R2_SQY;
            end
            mer_pkg::ST_R2_SQY:
            begin
                op         = mer_pkg::DP_R2_SQY;
                state_next = mer_pkg::ST_R2_C;
            end
            mer_pkg::ST_R2_C:
            begin
                op         = mer_pkg::DP_R2_C;
                state_next = mer_pkg::ST_R2_D;
            end
            mer_pkg::ST_R2_D:
            begin
                op         = mer_pkg::DP_R2_D;
                state_next = mer_pkg::ST_R2_INIT;
            end
            mer_pkg::ST_R2_INIT:
            begin
                op         = mer_pkg::DP_R2_INIT;
                state_next = mer_pkg::ST_R2_STEP;
            end
            mer_pkg::ST_R2_STEP:
            begin
                op         = mer_pkg::DP_R2_STEP;
                state_next = mer_pkg::ST_WALK;
            end
            default:
            begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mer_dp.sv =====
// Datapath: shared multiplier, decision and gradient registers, and the output register.
module mer_dp #(
    parameter int MAX_RADIUS  = mer_pkg::MAX_RADIUS_DEF,
    parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mer_pkg::dp_op_t                   op,
    output mer_pkg::dp_status_t               status,
    input  logic signed [COORD_WIDTH-1:0]     center_x,
    input  logic signed [COORD_WIDTH-1:0]     center_y,
    input  logic [mer_pkg::RAD_W-1:0]         radius_x,
    input  logic [mer_pkg::RAD_W-1:0]         radius_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_WIDTH:0]       pt0_x,
    output logic signed [COORD_WIDTH:0]       pt0_y,
    output logic signed [COORD_WIDTH:0]       pt1_x,
    output logic signed [COORD_WIDTH:0]       pt1_y,
    output logic signed [COORD_WIDTH:0]       pt2_x,
    output logic signed [COORD_WIDTH:0]       pt2_y,
    output logic signed [COORD_WIDTH:0]       pt3_x,
    output logic signed [COORD_WIDTH:0]       pt3_y,
    output logic                              last_step
);

    localparam int OUT_W   = COORD_WIDTH + 1;
    localparam int RAD_W   = mer_pkg::RAD_W;
    localparam int SQ_W    = mer_pkg::SQ_W;
    localparam int MUL_A_W = mer_pkg::MUL_A_W;
    localparam int MUL_B_W = mer_pkg::MUL_B_W;
    localparam int PROD_W  = mer_pkg::PROD_W;
    localparam int OFS_W   = mer_pkg::OFS_W;
    localparam int GRAD_W  = mer_pkg::GRAD_W;
    localparam int DEC_W   = mer_pkg::DEC_W;
    localparam int CNT_W   = mer_pkg::CNT_W;
    localparam logic [RAD_W-1:0] RAD_MAX  = RAD_W'(MAX_RADIUS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mer_pkg::MAX_RESULTS - 1);

    logic signed [COORD_WIDTH-1:0] cx_reg, cx_next;
    logic signed [COORD_WIDTH-1:0] cy_reg, cy_next;
    logic [RAD_W-1:0]              rx_reg, rx_next;
    logic [RAD_W-1:0]              ry_reg, ry_next;
    logic [SQ_W-1:0]               rx2_reg, rx2_next;
    logic [SQ_W-1:0]               ry2_reg, ry2_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic signed [DEC_W-1:0]       acc_reg, acc_next;
    logic signed [DEC_W-1:0]       p_reg, p_next;
    logic signed [GRAD_W-1:0]      px_reg, px_next;
    logic signed [GRAD_W-1:0]      py_reg, py_next;
    logic [OFS_W-1:0]              x_reg, x_next;
    logic [OFS_W-1:0]              y_reg, y_next;
    logic                          r2_reg, r2_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]       px_out_reg, px_out_next;
    logic signed [OUT_W-1:0]       nx_out_reg, nx_out_next;
    logic signed [OUT_W-1:0]       py_out_reg, py_out_next;
    logic signed [OUT_W-1:0]       ny_out_reg, ny_out_next;
    logic                          last_reg, last_next;

    logic [MUL_A_W-1:0]            mul_a;
    logic [MUL_B_W-1:0]            mul_b;
    logic [RAD_W-1:0]              rx_sat;
    logic [RAD_W-1:0]              ry_sat;
    logic [OFS_W-1:0]              y_m1_abs;
    logic [PROD_W:0]               prod_rnd;
    logic signed [DEC_W-1:0]       rx2_d;
    logic signed [DEC_W-1:0]       ry2_d;
    logic signed [DEC_W-1:0]       prod_d;
    logic signed [GRAD_W-1:0]      two_rx2;
    logic signed [GRAD_W-1:0]      two_ry2;
    logic                          emit_fire;
    logic                          step;
    logic                          last;

    logic                          r1_neg;
    logic signed [GRAD_W-1:0]      r1_px;
    logic signed [GRAD_W-1:0]      r1_py;
    logic signed [DEC_W-1:0]       r1_sub;
    logic signed [DEC_W-1:0]       r1_p;
    logic                          r2_stx;
    logic signed [GRAD_W-1:0]      r2_px;
    logic signed [GRAD_W-1:0]      r2_py;
    logic signed [DEC_W-1:0]       r2_add;
    logic signed [DEC_W-1:0]       r2_p;
    logic signed [OUT_W-1:0]       cx_e, cy_e, x_e, y_e;

    assign rx_sat   = (radius_x > RAD_MAX) ? RAD_MAX : radius_x;
    assign ry_sat   = (radius_y > RAD_MAX) ? RAD_MAX : radius_y;
    assign y_m1_abs = (y_reg == '0) ? OFS_W'(1) : y_reg - OFS_W'(1);
    assign prod_rnd = {1'b0, prod_reg} + (PROD_W + 1)'(2);

    assign rx2_d   = $signed(DEC_W'(rx2_reg));
    assign ry2_d   = $signed(DEC_W'(ry2_reg));
    assign prod_d  = $signed(DEC_W'(prod_reg));
    assign two_rx2 = $signed(GRAD_W'({rx2_reg, 1'b0}));
    assign two_ry2 = $signed(GRAD_W'({ry2_reg, 1'b0}));

    // Region one step
    assign r1_neg = p_reg[DEC_W-1];
    assign r1_px  = px_reg + two_ry2;
    assign r1_py  = r1_neg ? py_reg : py_reg - two_rx2;
    assign r1_sub = r1_neg ? '0 : DEC_W'(r1_py);
    assign r1_p   = p_reg + ry2_d + DEC_W'(r1_px) - r1_sub;

    // Region two step
    assign r2_stx = r1_neg || (p_reg == '0);
    assign r2_px  = r2_stx ? r1_px : px_reg;
    assign r2_py  = py_reg - two_rx2;
    assign r2_add = r2_stx ? DEC_W'(r2_px) : '0;
    assign r2_p   = p_reg + rx2_d - DEC_W'(r2_py) + r2_add;

    // No more points once y reaches the axis or the result budget runs out
    assign last      = (y_reg == '0) || (cnt_reg == CNT_LAST);
    assign emit_fire = (op == mer_pkg::DP_EMIT) && (!out_valid_reg || !out_stall);
    assign step      = emit_fire && !last;

    assign status.emit_ok = !out_valid_reg || !out_stall;
    assign status.last    = last;
    assign status.need_r2 = !r2_reg && !(px_reg < py_reg);

    assign cx_e = OUT_W'(cx_reg);
    assign cy_e = OUT_W'(cy_reg);
    assign x_e  = $signed(OUT_W'(x_reg));
    assign y_e  = $signed(OUT_W'(y_reg));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op) inside
            mer_pkg::DP_SQ_RX:
            begin
                mul_a = MUL_A_W'(rx_reg);
                mul_b = MUL_B_W'(rx_reg);
            end
            mer_pkg::DP_SQ_RY:
            begin
                mul_a = MUL_A_W'(ry_reg);
                mul_b = MUL_B_W'(ry_reg);
            end
            mer_pkg::DP_R1_MUL:
            begin
                mul_a = MUL_A_W'(rx2_reg);
                mul_b = MUL_B_W'(ry_reg);
            end
            mer_pkg::DP_R2_SQX:
            begin
                mul_a = MUL_A_W'({x_reg, 1'b1});
                mul_b = MUL_B_W'({x_reg, 1'b1});
            end
            mer_pkg::DP_R2_A:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = ry2_reg;
            end
            mer_pkg::DP_R2_SQY:
            begin
                mul_a = MUL_A_W'(y_m1_abs);
                mul_b = MUL_B_W'(y_m1_abs);
            end
            mer_pkg::DP_R2_C:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = rx2_reg;
            end
            mer_pkg::DP_R2_D:
            begin
                mul_a = MUL_A_W'(ry2_reg);
                mul_b = rx2_reg;
            end
            mer_pkg::DP_NOP, mer_pkg::DP_LOAD, mer_pkg::DP_R1_INIT, mer_pkg::DP_EMIT,
            mer_pkg::DP_R2_INIT, mer_pkg::DP_R2_STEP:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rx2_next       = rx2_reg;
        ry2_next       = ry2_reg;
        prod_next      = PROD_W'(mul_a) * PROD_W'(mul_b);
        acc_next       = acc_reg;
        p_next         = p_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        r2_next        = r2_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        px_out_next    = px_out_reg;
        nx_out_next    = nx_out_reg;
        py_out_next    = py_out_reg;
        ny_out_next    = ny_out_reg;
        last_next      = last_reg;

        unique case (op) inside
            mer_pkg::DP_LOAD:
            begin
                cx_next = center_x;
                cy_next = center_y;
                rx_next = rx_sat;
                ry_next = ry_sat;
            end
            mer_pkg::DP_SQ_RY:
            begin
                rx2_next = prod_reg[SQ_W-1:0];
            end
            mer_pkg::DP_R1_MUL:
            begin
                ry2_next = prod_reg[SQ_W-1:0];
            end
            mer_pkg::DP_R1_INIT:
            begin
                // floor((4ry2 - 4rx2*ry + rx2 + 2) / 4)
                p_next   = ry2_d - prod_d + DEC_W'((rx2_reg + SQ_W'(2)) >> 2);
                px_next  = '0;
                py_next  = $signed(GRAD_W'({prod_reg, 1'b0}));
                x_next   = '0;
                y_next   = OFS_W'(ry_reg);
                r2_next  = 1'b0;
                cnt_next = '0;
            end
            mer_pkg::DP_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    px_out_next    = cx_e + x_e;
                    nx_out_next    = cx_e - x_e;
                    py_out_next    = cy_e + y_e;
                    ny_out_next    = cy_e - y_e;
                    last_next      = last;
                    cnt_next       = cnt_reg + CNT_W'(1);
                end
                if (step && r2_reg)
                begin
                    p_next  = r2_p;
                    px_next = r2_px;
                    py_next = r2_py;
                    y_next  = y_reg - OFS_W'(1);
                    x_next  = r2_stx ? x_reg + OFS_W'(1) : x_reg;
                end
                else if (step && (px_reg < py_reg))
                begin
                    p_next  = r1_p;
                    px_next = r1_px;
                    py_next = r1_py;
                    x_next  = x_reg + OFS_W'(1);
                    y_next  = r1_neg ? y_reg : y_reg - OFS_W'(1);
                end
            end
            mer_pkg::DP_R2_SQY:
            begin
                // ry2*(2x+1)^2 rounded to quarters; the other terms are whole multiples of 4
                acc_next = $signed(DEC_W'(prod_rnd[PROD_W:2]));
            end
            mer_pkg::DP_R2_D:
            begin
                acc_next = acc_reg + prod_d;
            end
            mer_pkg::DP_R2_INIT:
            begin
                p_next  = acc_reg - prod_d;
                r2_next = 1'b1;
            end
            mer_pkg::DP_R2_STEP:
            begin
                p_next  = r2_p;
                px_next = r2_px;
                py_next = r2_py;
                y_next  = y_reg - OFS_W'(1);
                x_next  = r2_stx ? x_reg + OFS_W'(1) : x_reg;
            end
            mer_pkg::DP_NOP, mer_pkg::DP_SQ_RX, mer_pkg::DP_R2_SQX, mer_pkg::DP_R2_A,
            mer_pkg::DP_R2_C:
            begin
                acc_next = acc_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        rx2_reg    <= rx2_next;
        ry2_reg    <= ry2_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        r2_reg     <= r2_next;
        cnt_reg    <= cnt_next;
        px_out_reg <= px_out_next;
        nx_out_reg <= nx_out_next;
        py_out_reg <= py_out_next;
        ny_out_reg <= ny_out_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign pt0_x     = px_out_reg;
    assign pt0_y     = py_out_reg;
    assign pt1_x     = nx_out_reg;
    assign pt1_y     = py_out_reg;
    assign pt2_x     = px_out_reg;
    assign pt2_y     = ny_out_reg;
    assign pt3_x     = nx_out_reg;
    assign pt3_y     = ny_out_reg;
    assign last_step = last_reg;

endmodule

// ===== rtl/midpoint_ellipse_rasterizer_core.sv =====
// After the input transfer the sequencer runs the setup multiplies and decision load, then
// emits one point set per cycle while out_stall is low. An ellipse gives n <= 63 results; on
// entering region two it runs five multiplies, decision load and the first region-two step.
// The input is taken again the cycle after the last result enters the output register.
// Reset clears the sequencer and the output valid; datapath registers load before use.
module midpoint_ellipse_rasterizer_core #(
    parameter int MAX_RADIUS  = mer_pkg::MAX_RADIUS_DEF,
    parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic [mer_pkg::RAD_W-1:0]     radius_x,
    input  logic [mer_pkg::RAD_W-1:0]     radius_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH:0]   pt0_x,
    output logic signed [COORD_WIDTH:0]   pt0_y,
    output logic signed [COORD_WIDTH:0]   pt1_x,
    output logic signed [COORD_WIDTH:0]   pt1_y,
    output logic signed [COORD_WIDTH:0]   pt2_x,
    output logic signed [COORD_WIDTH:0]   pt2_y,
    output logic signed [COORD_WIDTH:0]   pt3_x,
    output logic signed [COORD_WIDTH:0]   pt3_y,
    output logic                          last_step
);

    mer_pkg::dp_op_t     op;
    mer_pkg::dp_status_t status;

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    mer_dp #(
        .MAX_RADIUS  (MAX_RADIUS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius_x  (radius_x),
        .radius_y  (radius_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pt0_x     (pt0_x),
        .pt0_y     (pt0_y),
        .pt1_x     (pt1_x),
        .pt1_y     (pt1_y),
        .pt2_x     (pt2_x),
        .pt2_y     (pt2_y),
        .pt3_x     (pt3_x),
        .pt3_y     (pt3_y),
        .last_step (last_step)
    );

endmodule
